[design/sae_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Suffix automaton engine package
// Shared sizes, command codes, sequencer steps and status bundle.
// ----------------------------------------------------------------------------
package sae_pkg;

    // Block sizes.
    localparam int MAX_TEXT  = 256;
    localparam int CHAR_BITS = 8;
    localparam int POS_BITS  = 16;

    // Derived sizes.
    localparam int STATE_CAP = 2 * MAX_TEXT;
    localparam int ST_BITS   = $clog2(STATE_CAP);
    localparam int LINK_BITS = ST_BITS + 1;
    localparam int LEN_BITS  = $clog2(MAX_TEXT + 1);
    localparam int TR_ABITS  = ST_BITS + CHAR_BITS;
    localparam logic [LINK_BITS-1:0] LINK_NONE = LINK_BITS'(STATE_CAP);
    localparam logic [POS_BITS-1:0]  POS_MAX   = '1;

    // Payload field widths.
    localparam int CMD_W   = 3;
    localparam int SYM_W   = 8;
    localparam int BLEN_W  = 9;
    localparam int BEND_W  = 16;
    localparam int DCNT_W  = 16;
    localparam int SDATA_W = 16;
    localparam int MDATA_W = 48;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 3'd0,
        CMD_APPEND  = 3'd1,
        CMD_CONTAIN = 3'd2,
        CMD_LCS     = 3'd3,
        CMD_COUNT   = 3'd4
    } t_cmd;

    // Sequencer steps, one-hot.
    localparam int STEP_W = 28;
    typedef enum logic [STEP_W-1:0] {
        ST_CLR  = 28'd1 << 0,
        ST_IDLE = 28'd1 << 1,
        ST_DISP = 28'd1 << 2,
        ST_A0   = 28'd1 << 3,
        ST_A1   = 28'd1 << 4,
        ST_W    = 28'd1 << 5,
        ST_W1   = 28'd1 << 6,
        ST_W2   = 28'd1 << 7,
        ST_W3   = 28'd1 << 8,
        ST_C0   = 28'd1 << 9,
        ST_CPR  = 28'd1 << 10,
        ST_CPW  = 28'd1 << 11,
        ST_R    = 28'd1 << 12,
        ST_R1   = 28'd1 << 13,
        ST_F2A  = 28'd1 << 14,
        ST_F2B  = 28'd1 << 15,
        ST_FIN  = 28'd1 << 16,
        ST_Q1   = 28'd1 << 17,
        ST_Q2   = 28'd1 << 18,
        ST_L1   = 28'd1 << 19,
        ST_L2   = 28'd1 << 20,
        ST_LW   = 28'd1 << 21,
        ST_LW1  = 28'd1 << 22,
        ST_LEND = 28'd1 << 23,
        ST_D1   = 28'd1 << 24,
        ST_D2   = 28'd1 << 25,
        ST_D3   = 28'd1 << 26,
        ST_RES  = 28'd1 << 27
    } t_step;

    // Datapath status seen by the controller.
    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic alive;
        logic p_none;
        logic tr_zero;
        logic tr_is_q;
        logic len_match;
        logic copy_last;
        logic clr_last;
        logic idx_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

[design/sae_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Suffix automaton engine controller
// Sequences each request through memory access steps of the datapath.
// ----------------------------------------------------------------------------
module sae_ctrl
    import sae_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output t_step        o_step
);

    t_step r_step, n_step;
    logic  r_clr_rsp, n_clr_rsp;

    // Next step selection.
    always_comb begin
        n_step    = r_step;
        n_clr_rsp = r_clr_rsp;
        unique case (r_step)
            ST_CLR: begin
                if (i_status.clr_last) begin
                    n_step = r_clr_rsp ? ST_RES : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_step = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (i_status.cmd)
                    CMD_CLEAR: begin
                        n_step    = ST_CLR;
                        n_clr_rsp = 1'b1;
                    end
                    CMD_APPEND:  n_step = i_status.full ? ST_RES : ST_A0;
                    CMD_CONTAIN: n_step = ST_Q1;
                    CMD_LCS:     n_step = ST_L1;
                    CMD_COUNT:   n_step = ST_D1;
                    default:     n_step = ST_RES;
                endcase
            end
            ST_A0:  n_step = ST_A1;
            ST_A1:  n_step = ST_W;
            ST_W:   n_step = i_status.p_none ? ST_FIN : ST_W1;
            ST_W1:  n_step = i_status.tr_zero ? ST_W : ST_W2;
            ST_W2:  n_step = ST_W3;
            ST_W3:  n_step = i_status.len_match ? ST_FIN : ST_C0;
            ST_C0:  n_step = ST_CPR;
            ST_CPR: n_step = ST_CPW;
            ST_CPW: n_step = i_status.copy_last ? ST_R : ST_CPR;
            ST_R:   n_step = i_status.p_none ? ST_F2A : ST_R1;
            ST_R1:  n_step = i_status.tr_is_q ? ST_R : ST_F2A;
            ST_F2A: n_step = ST_F2B;
            ST_F2B: n_step = ST_FIN;
            ST_FIN: n_step = ST_RES;
            ST_Q1:  n_step = i_status.alive ? ST_Q2 : ST_RES;
            ST_Q2:  n_step = ST_RES;
            ST_L1:  n_step = ST_L2;
            ST_L2:  n_step = i_status.tr_zero ? ST_LW : ST_LEND;
            ST_LW:  n_step = i_status.p_none ? ST_LEND : ST_LW1;
            ST_LW1: n_step = i_status.tr_zero ? ST_LW : ST_LEND;
            ST_LEND: n_step = ST_RES;
            ST_D1:  n_step = i_status.idx_done ? ST_RES : ST_D2;
            ST_D2:  n_step = ST_D3;
            ST_D3:  n_step = ST_D1;
            ST_RES: begin
                if (i_status.out_free) begin
                    n_step    = ST_IDLE;
                    n_clr_rsp = 1'b0;
                end
            end
            default: n_step = ST_CLR;
        endcase
    end

    // Step register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_CLR;
            r_clr_rsp <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_clr_rsp <= n_clr_rsp;
        end
    end

    assign o_step = r_step;

    // A clone copy loop never ends without reaching its last symbol.
    a_copy_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_CPW && !i_status.copy_last) |=> (r_step == ST_CPR))
        else $error("copy loop left early");

    // A clearing pass only ends in a response when a clear request started it.
    a_clr_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_CLR && n_step == ST_RES) |-> r_clr_rsp)
        else $error("clear response without a clear request");

    // Every request leaves idle through dispatch.
    a_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_IDLE && i_in_valid) |=> (r_step == ST_DISP))
        else $error("accepted request not dispatched");

endmodule
`default_nettype wire

[design/sae_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Suffix automaton engine datapath
// Holds the transition, length and link memories, the automaton and query
// registers, and the output register.
// ----------------------------------------------------------------------------
module sae_datapath
    import sae_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_step              i_step,
    input  wire logic               i_s_tvalid,
    input  wire logic [SDATA_W-1:0] i_s_tdata,
    input  wire logic               i_s_tuser,
    input  wire logic               i_s_tlast,
    input  wire logic               i_m_tready,
    output logic                    o_s_tready,
    output logic                    o_m_tvalid,
    output logic [MDATA_W-1:0]      o_m_tdata,
    output t_status                 o_status
);

    // Memories.
    logic [ST_BITS-1:0]   trans_mem [2**TR_ABITS];
    logic [LEN_BITS-1:0]  len_mem   [STATE_CAP];
    logic [LINK_BITS-1:0] link_mem  [STATE_CAP];

    logic [ST_BITS-1:0]   r_tr_q;
    logic [LEN_BITS-1:0]  r_len_q;
    logic [LINK_BITS-1:0] r_link_q;

    logic                 tr_we, len_we, link_we;
    logic [TR_ABITS-1:0]  tr_wa, tr_ra;
    logic [ST_BITS-1:0]   tr_wd;
    logic [ST_BITS-1:0]   len_wa, len_ra, link_wa, link_ra;
    logic [LEN_BITS-1:0]  len_wd;
    logic [LINK_BITS-1:0] link_wd;

    // Request latch.
    t_cmd                 r_cmd;
    logic [CHAR_BITS-1:0] r_sym;
    logic                 r_first, r_last, r_full;

    // Automaton and query registers.
    logic [LINK_BITS-1:0] r_states_used;
    logic [ST_BITS-1:0]   r_final, r_cursor, r_cur, r_q, r_cl;
    logic [LEN_BITS-1:0]  r_text_len, r_run, r_best, r_lp;
    logic                 r_alive;
    logic [POS_BITS-1:0]  r_bpos, r_qpos;
    logic [LINK_BITS-1:0] r_p, r_idx;
    logic [CHAR_BITS-1:0] r_cidx;
    logic [TR_ABITS-1:0]  r_clr_cnt;
    logic [DCNT_W-1:0]    r_sum;

    // Output register.
    logic                 r_m_valid;
    logic                 r_o_found, r_o_full;
    logic [BLEN_W-1:0]    r_o_blen;
    logic [BEND_W-1:0]    r_o_bend;
    logic [DCNT_W-1:0]    r_o_dcnt;

    logic [ST_BITS-1:0]   p_st;
    logic                 accept, out_free;

    assign p_st     = r_p[ST_BITS-1:0];
    assign accept   = (i_step == ST_IDLE) && i_s_tvalid;
    assign out_free = !r_m_valid || i_m_tready;

    // Status toward the controller.
    always_comb begin
        o_status.cmd       = r_cmd;
        o_status.full      = (r_text_len >= LEN_BITS'(MAX_TEXT));
        o_status.alive     = r_alive;
        o_status.p_none    = (r_p == LINK_NONE);
        o_status.tr_zero   = (r_tr_q == '0);
        o_status.tr_is_q   = (r_tr_q == r_q);
        o_status.len_match = (LEN_BITS'(r_lp + 1'b1) == r_len_q);
        o_status.copy_last = (&r_cidx);
        o_status.clr_last  = (&r_clr_cnt);
        o_status.idx_done  = (r_idx >= r_states_used);
        o_status.out_free  = out_free;
    end

    // Memory port selection for each step.
    always_comb begin
        tr_we   = 1'b0;
        tr_wa   = {p_st, r_sym};
        tr_wd   = r_cur;
        tr_ra   = {p_st, r_sym};
        len_we  = 1'b0;
        len_wa  = r_cur;
        len_wd  = LEN_BITS'(r_len_q + 1'b1);
        len_ra  = p_st;
        link_we = 1'b0;
        link_wa = r_cur;
        link_wd = LINK_BITS'(r_cl);
        link_ra = p_st;
        unique case (i_step)
            ST_CLR: begin
                tr_we = 1'b1;
                tr_wa = r_clr_cnt;
                tr_wd = '0;
                if (r_clr_cnt == '0) begin
                    len_we  = 1'b1;
                    len_wa  = '0;
                    len_wd  = '0;
                    link_we = 1'b1;
                    link_wa = '0;
                    link_wd = LINK_NONE;
                end
            end
            ST_A0: len_ra = r_final;
            ST_A1: len_we = 1'b1;
            ST_W: begin
                if (r_p == LINK_NONE) begin
                    link_we = 1'b1;
                    link_wd = '0;
                end
            end
            ST_W1: tr_we = (r_tr_q == '0);
            ST_W2: len_ra = r_q;
            ST_W3: begin
                if (LEN_BITS'(r_lp + 1'b1) == r_len_q) begin
                    link_we = 1'b1;
                    link_wd = LINK_BITS'(r_q);
                end else begin
                    len_we  = 1'b1;
                    len_wa  = r_states_used[ST_BITS-1:0];
                    len_wd  = LEN_BITS'(r_lp + 1'b1);
                    link_ra = r_q;
                end
            end
            ST_C0: begin
                link_we = 1'b1;
                link_wa = r_cl;
                link_wd = r_link_q;
            end
            ST_CPR: tr_ra = {r_q, r_cidx};
            ST_CPW: begin
                tr_we = 1'b1;
                tr_wa = {r_cl, r_cidx};
                tr_wd = r_tr_q;
            end
            ST_R1: begin
                tr_we = (r_tr_q == r_q);
                tr_wd = r_cl;
            end
            ST_F2A: begin
                link_we = 1'b1;
                link_wa = r_q;
            end
            ST_F2B: link_we = 1'b1;
            ST_Q1:  tr_ra = {r_cursor, r_sym};
            ST_L1:  tr_ra = {r_cursor, r_sym};
            ST_D1: begin
                len_ra  = r_idx[ST_BITS-1:0];
                link_ra = r_idx[ST_BITS-1:0];
            end
            ST_D2: len_ra = r_link_q[ST_BITS-1:0];
            default: begin
                tr_we = 1'b0;
            end
        endcase
    end

    // Transition memory.
    always_ff @(posedge i_clk) begin
        if (tr_we) begin
            trans_mem[tr_wa] <= tr_wd;
        end
        r_tr_q <= trans_mem[tr_ra];
    end

    // Length memory.
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            len_mem[len_wa] <= len_wd;
        end
        r_len_q <= len_mem[len_ra];
    end

    // Suffix link memory.
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        r_link_q <= link_mem[link_ra];
    end

    // Request latch; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= t_cmd'(i_s_tdata[CMD_W-1:0]);
            r_sym   <= CHAR_BITS'(i_s_tdata[CMD_W +: SYM_W]);
            r_first <= i_s_tuser;
            r_last  <= i_s_tlast;
        end
        if (i_step == ST_DISP) begin
            r_full <= (r_text_len >= LEN_BITS'(MAX_TEXT));
        end
    end

    // Automaton and query registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt     <= '0;
            r_states_used <= LINK_BITS'(1);
            r_final       <= '0;
            r_text_len    <= '0;
            r_cursor      <= '0;
            r_run         <= '0;
            r_alive       <= 1'b1;
            r_best        <= '0;
            r_bpos        <= '0;
            r_qpos        <= '0;
        end else begin
            unique case (i_step)
                ST_CLR: begin
                    r_clr_cnt     <= r_clr_cnt + 1'b1;
                    r_states_used <= LINK_BITS'(1);
                    r_final       <= '0;
                    r_text_len    <= '0;
                    r_cursor      <= '0;
                    r_run         <= '0;
                    r_alive       <= 1'b1;
                    r_best        <= '0;
                    r_bpos        <= '0;
                    r_qpos        <= '0;
                end
                ST_DISP: begin
                    if (r_cmd == CMD_CLEAR) begin
                        r_clr_cnt <= '0;
                    end
                    if (r_cmd == CMD_CONTAIN && r_first) begin
                        r_cursor <= '0;
                        r_alive  <= 1'b1;
                    end
                    if (r_cmd == CMD_LCS && r_first) begin
                        r_cursor <= '0;
                        r_run    <= '0;
                        r_best   <= '0;
                        r_bpos   <= '0;
                        r_qpos   <= '0;
                    end
                    r_sum <= '0;
                    r_idx <= LINK_BITS'(1);
                end
                ST_A0: begin
                    r_cur         <= r_states_used[ST_BITS-1:0];
                    r_p           <= LINK_BITS'(r_final);
                    r_states_used <= r_states_used + 1'b1;
                end
                ST_W1: begin
                    if (r_tr_q == '0) begin
                        r_p <= r_link_q;
                    end else begin
                        r_q <= r_tr_q;
                    end
                end
                ST_W2: r_lp <= r_len_q;
                ST_W3: begin
                    if (LEN_BITS'(r_lp + 1'b1) != r_len_q) begin
                        r_cl          <= r_states_used[ST_BITS-1:0];
                        r_states_used <= r_states_used + 1'b1;
                    end
                end
                ST_C0:  r_cidx <= '0;
                ST_CPW: r_cidx <= r_cidx + 1'b1;
                ST_R1: begin
                    if (r_tr_q == r_q) begin
                        r_p <= r_link_q;
                    end
                end
                ST_FIN: begin
                    r_final    <= r_cur;
                    r_text_len <= r_text_len + 1'b1;
                end
                ST_Q2: begin
                    if (r_tr_q == '0) begin
                        r_alive <= 1'b0;
                    end else begin
                        r_cursor <= r_tr_q;
                    end
                end
                ST_L2: begin
                    if (r_tr_q != '0) begin
                        r_run    <= r_run + 1'b1;
                        r_cursor <= r_tr_q;
                    end else begin
                        r_p <= LINK_BITS'(r_cursor);
                    end
                end
                ST_LW: begin
                    if (r_p == LINK_NONE) begin
                        r_cursor <= '0;
                        r_run    <= '0;
                    end
                end
                ST_LW1: begin
                    if (r_tr_q == '0) begin
                        r_p <= r_link_q;
                    end else begin
                        r_run    <= LEN_BITS'(r_len_q + 1'b1);
                        r_cursor <= r_tr_q;
                    end
                end
                ST_LEND: begin
                    if (r_run > r_best) begin
                        r_best <= r_run;
                        r_bpos <= r_qpos;
                    end
                    if (r_qpos != POS_MAX) begin
                        r_qpos <= r_qpos + 1'b1;
                    end
                end
                ST_D2: r_lp <= r_len_q;
                ST_D3: begin
                    r_sum <= r_sum + DCNT_W'(LEN_BITS'(r_lp - r_len_q));
                    r_idx <= r_idx + 1'b1;
                end
                default: begin
                    r_clr_cnt <= r_clr_cnt;
                end
            endcase
        end
    end

    // Output register: loaded when the result step finds the slot free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_step == ST_RES && out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step == ST_RES && out_free) begin
            r_o_found <= (r_cmd == CMD_CONTAIN) && r_last && r_alive;
            r_o_blen  <= (r_cmd == CMD_LCS) ? BLEN_W'(r_best) : '0;
            r_o_bend  <= (r_cmd == CMD_LCS) ? BEND_W'(r_bpos) : '0;
            r_o_dcnt  <= (r_cmd == CMD_COUNT) ? r_sum : '0;
            r_o_full  <= (r_cmd == CMD_APPEND) && r_full;
        end
    end

    assign o_s_tready = (i_step == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {5'b0, r_o_full, r_o_dcnt, r_o_bend, r_o_blen, r_o_found};

    // The text never grows past its capacity.
    a_text_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_text_len <= LEN_BITS'(MAX_TEXT))
        else $error("text length above capacity");

    // State allocation stays within the store.
    a_state_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_states_used <= LINK_BITS'(STATE_CAP))
        else $error("state count above capacity");

    // A result is never loaded over one that has not been taken.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_m_tready && i_step == ST_RES) |=> $stable(r_o_dcnt))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

[design/suffix_automaton_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Suffix automaton engine
// Builds a suffix automaton over streamed text and answers streamed queries.
// ----------------------------------------------------------------------------
// One request is worked at a time, each a sequence of single-port memory
// steps, and each request gives one result. After reset, and after a clear
// request, a clearing pass writes the transition memory one entry per cycle,
// all 2^(9+CHAR_BITS) = 131072 entries, during which no request is taken. An
// append walks the suffix links and stops at an existing transition or past
// the root; an append to a full text is dropped. A clone copies the row of
// 2^CHAR_BITS = 256 entries through the transition memory port, then
// redirects the transitions that pointed at the cloned state. A containment
// step follows at most one transition. An LCS step follows the cursor's
// transition if it has one, otherwise suffix links until one has it or the
// walk runs past the root. A distinct count visits every state. A new
// request can be taken while a result waits.
// ----------------------------------------------------------------------------
module suffix_automaton_engine
    import sae_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [SDATA_W-1:0] s_tdata,  // command[2:0], symbol[10:3], zero
    input  wire logic               s_tuser,  // first
    input  wire logic               s_tlast,  // last
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [MDATA_W-1:0]      m_tdata   // found, best_length, best_end,
                                              // distinct_count, full_res, zero
);

    t_step   step;
    t_status status;

    // Sequencer.
    sae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_status   (status),
        .o_step     (step)
    );

    // Memories and registers.
    sae_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_s_tvalid (s_tvalid),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .i_m_tready (m_tready),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_status   (status)
    );

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Suffix automaton engine testbench
// Streams append, containment, LCS, count, clear and unused requests into the
// engine, predicts each result with an in-bench copy of the automaton, and
// checks every result field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import sae_pkg::*;

    // Run sizes.
    localparam int N_ITEMS    = 1250;
    localparam int IDLE_LIMIT = 400000;
    localparam int TR_DEPTH   = STATE_CAP << CHAR_BITS;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
    localparam logic [7:0] SYM_A = 8'h61;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SYM_W-1:0] sym;
        logic             first;
        logic             last;
        logic             hold;  // wait until no result is outstanding
    } t_request;

    typedef struct packed {
        logic              found;
        logic [BLEN_W-1:0] blen;
        logic [BEND_W-1:0] bend;
        logic [DCNT_W-1:0] dcnt;
        logic              full;
    } t_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [SDATA_W-1:0] s_tdata;
    logic               s_tuser;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [MDATA_W-1:0] m_tdata;

    t_request pending_reqs[$];
    t_answer  expected_answers[$];
    t_request cur_req;
    logic [7:0] text_shadow[$];
    int errors;
    int sent;
    int watchdog;
    int cmd_seen[8];

    // Automaton copy used for prediction.
    logic [LEN_BITS-1:0]  am_len[STATE_CAP];
    logic [LINK_BITS-1:0] am_link[STATE_CAP];
    logic [ST_BITS-1:0]   am_next[TR_DEPTH];
    int am_states, am_final, am_text;
    int am_cursor, am_run, am_alive, am_best, am_best_pos, am_qpos;

    suffix_automaton_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic int clamp_state(input int s);
        return (s < STATE_CAP) ? s : 0;
    endfunction

    function automatic int tr_index(input int s, input int c);
        return (clamp_state(s) << CHAR_BITS) | (c & ((1 << CHAR_BITS) - 1));
    endfunction

    function automatic void automaton_clear();
        for (int i = 0; i < TR_DEPTH; i++) am_next[i] = '0;
        for (int i = 0; i < STATE_CAP; i++) begin
            am_len[i]  = '0;
            am_link[i] = '0;
        end
        am_link[0] = LINK_NONE;
        am_states = 1; am_final = 0; am_text = 0;
        am_cursor = 0; am_run = 0; am_alive = 1;
        am_best = 0; am_best_pos = 0; am_qpos = 0;
    endfunction

    // Standard online construction, cloning where the length test fails.
    function automatic void automaton_extend(input int c);
        int cur, p, q, cl;
        cur = clamp_state(am_states);
        p = am_final;
        am_states++;
        am_len[cur] = am_len[clamp_state(am_final)] + 1;
        while (p != LINK_NONE && am_next[tr_index(p, c)] == 0) begin
            am_next[tr_index(p, c)] = cur;
            p = am_link[clamp_state(p)];
        end
        if (p == LINK_NONE) begin
            am_link[cur] = '0;
        end else begin
            q = clamp_state(am_next[tr_index(p, c)]);
            if (am_len[clamp_state(p)] + 1 == am_len[q]) begin
                am_link[cur] = q;
            end else begin
                cl = clamp_state(am_states);
                am_states++;
                am_len[cl] = am_len[clamp_state(p)] + 1;
                for (int k = 0; k < (1 << CHAR_BITS); k++)
                    am_next[tr_index(cl, k)] = am_next[tr_index(q, k)];
                am_link[cl] = am_link[q];
                while (p != LINK_NONE && am_next[tr_index(p, c)] == q) begin
                    am_next[tr_index(p, c)] = cl;
                    p = am_link[clamp_state(p)];
                end
                am_link[q]   = cl;
                am_link[cur] = cl;
            end
        end
        am_final = cur;
        am_text++;
    endfunction

    // Works out the result of one accepted request and updates the copy.
    function automatic t_answer automaton_answer(input t_request r);
        t_answer a;
        int c, nxt, pos, cur;
        longint sum;
        a = '0;
        c = r.sym;
        case (r.cmd)
            CMD_CLEAR: automaton_clear();
            CMD_APPEND: begin
                if (am_text >= MAX_TEXT) a.full = 1'b1;
                else automaton_extend(c);
            end
            CMD_CONTAIN: begin
                if (r.first) begin
                    am_cursor = 0; am_alive = 1;
                end
                if (am_alive != 0) begin
                    nxt = am_next[tr_index(am_cursor, c)];
                    if (nxt == 0) am_alive = 0;
                    else am_cursor = clamp_state(nxt);
                end
                if (r.last) a.found = (am_alive != 0);
            end
            CMD_LCS: begin
                if (r.first) begin
                    am_cursor = 0; am_run = 0; am_best = 0;
                    am_best_pos = 0; am_qpos = 0;
                end
                pos = am_qpos;
                cur = clamp_state(am_cursor);
                if (am_next[tr_index(cur, c)] != 0) begin
                    am_run++;
                    cur = am_next[tr_index(cur, c)];
                end else begin
                    while (cur != LINK_NONE && am_next[tr_index(cur, c)] == 0)
                        cur = am_link[clamp_state(cur)];
                    if (cur == LINK_NONE) begin
                        cur = 0; am_run = 0;
                    end else begin
                        am_run = am_len[clamp_state(cur)] + 1;
                        cur = am_next[tr_index(cur, c)];
                    end
                end
                am_cursor = clamp_state(cur);
                if (am_run > am_best) begin
                    am_best = am_run; am_best_pos = pos;
                end
                if (am_qpos < POS_MAX) am_qpos++;
                a.blen = am_best;
                a.bend = am_best_pos;
            end
            CMD_COUNT: begin
                sum = 0;
                for (int i = 1; i < am_states && i < STATE_CAP; i++)
                    sum += longint'(am_len[i]) - am_len[clamp_state(am_link[i])];
                a.dcnt = sum;
            end
            default: ;
        endcase
        return a;
    endfunction

    // Request building, keeping a shadow of the text for meaningful queries.
    function automatic void add_request(input logic [CMD_W-1:0] cmd, input logic [7:0] sym,
                                        input logic first, input logic last,
                                        input logic hold = 1'b0);
        pending_reqs.push_back({cmd, sym, first, last, hold});
        if (cmd == CMD_CLEAR) text_shadow.delete();
        else if (cmd == CMD_APPEND && text_shadow.size() < MAX_TEXT)
            text_shadow.push_back(sym);
    endfunction

    function automatic void add_query(input logic [CMD_W-1:0] cmd, input int qlen,
                                      input logic with_first);
        int start;
        logic [7:0] sym;
        start = (text_shadow.size() > 0) ? $urandom_range(0, text_shadow.size() - 1) : 0;
        for (int i = 0; i < qlen; i++) begin
            if (start + i < text_shadow.size() && $urandom_range(0, 9) != 0)
                sym = text_shadow[start + i];
            else
                sym = SYM_A + $urandom_range(0, 4);
            add_request(cmd, sym, with_first && i == 0, i == qlen - 1);
        end
    endfunction

    // Request driver with phase-dependent idling.
    always @(posedge i_clk) begin
        logic accepted, idle;
        int phase, pct;
        t_request nreq;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
        end else begin
            accepted = s_tvalid && s_tready;
            if (accepted) begin
                expected_answers.push_back(automaton_answer(cur_req));
                cmd_seen[cur_req.cmd]++;
                sent++;
            end
            if (!s_tvalid || accepted) begin
                phase = sent * 3 / N_ITEMS;
                pct = (phase == 0) ? 12 : (phase == 1) ? 63 : 0;
                idle = $urandom_range(0, 99) < pct;
                if (pending_reqs.size() > 0 && !idle &&
                    (!pending_reqs[0].hold || expected_answers.size() == 0)) begin
                    nreq = pending_reqs.pop_front();
                    cur_req  <= nreq;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, nreq.sym, nreq.cmd};
                    s_tuser  <= nreq.first;
                    s_tlast  <= nreq.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result stall generator.
    always @(posedge i_clk) begin
        int phase, pct;
        phase = sent * 3 / N_ITEMS;
        pct = (phase == 0) ? 63 : (phase == 1) ? 12 : 0;
        m_tready <= !i_rst_n ? 1'b0 : ($urandom_range(0, 99) >= pct);
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_answer e, got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[9:1], m_tdata[25:10], m_tdata[41:26], m_tdata[42]};
            if (expected_answers.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                errors++;
            end else begin
                e = expected_answers.pop_front();
                if (got.found !== e.found) begin
                    $error("found: expected %0d, got %0d", e.found, got.found); errors++;
                end
                if (got.blen !== e.blen) begin
                    $error("best_length: expected %0d, got %0d", e.blen, got.blen); errors++;
                end
                if (got.bend !== e.bend) begin
                    $error("best_end: expected %0d, got %0d", e.bend, got.bend); errors++;
                end
                if (got.dcnt !== e.dcnt) begin
                    $error("distinct_count: expected %0d, got %0d", e.dcnt, got.dcnt);
                    errors++;
                end
                if (got.full !== e.full) begin
                    $error("full_res: expected %0d, got %0d", e.full, got.full); errors++;
                end
                if (m_tdata[47:43] !== '0) begin
                    $error("pad bits: expected 0, got %h", m_tdata[47:43]); errors++;
                end
            end
        end
    end

    // Watchdog on handshake activity; covers the clearing pass after a clear.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            watchdog <= 0;
        end else if (watchdog >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    initial begin
        int r;
        logic [7:0] sym;
        string seed;
        errors = 0;
        sent = 0;
        watchdog = 0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        seed = "abcbcab";
        foreach (cmd_seen[i]) cmd_seen[i] = 0;
        automaton_clear();

        // Directed: empty text, clones, extreme symbols, misses, unused codes.
        add_request(CMD_COUNT, 8'h00, 1'b0, 1'b0);
        add_request(CMD_CONTAIN, SYM_A, 1'b1, 1'b1);
        add_request(CMD_LCS, 8'hFF, 1'b1, 1'b1);
        foreach (seed[i]) add_request(CMD_APPEND, seed[i], 1'b0, 1'b0);
        add_request(CMD_APPEND, 8'hFF, 1'b0, 1'b0);
        add_request(CMD_APPEND, 8'h00, 1'b0, 1'b0);
        add_request(CMD_COUNT, 8'hFF, 1'b1, 1'b1);
        add_request(CMD_CONTAIN, "b", 1'b1, 1'b0);
        add_request(CMD_CONTAIN, "c", 1'b0, 1'b1);
        add_request(CMD_CONTAIN, "z", 1'b1, 1'b0);
        add_request(CMD_CONTAIN, "a", 1'b0, 1'b1);
        add_request(CMD_LCS, "x", 1'b1, 1'b0);
        add_request(CMD_LCS, "b", 1'b0, 1'b0);
        add_request(CMD_LCS, "c", 1'b0, 1'b0);
        add_request(CMD_LCS, "b", 1'b0, 1'b1, 1'b1);
        add_request(CMD_CONTAIN, "c", 1'b0, 1'b1);
        add_request(CMD_UNUSED_LO, 8'hAA, 1'b1, 1'b1);
        add_request(CMD_UNUSED_HI, 8'h55, 1'b0, 1'b1);
        add_request(CMD_CLEAR, 8'hFF, 1'b1, 1'b1);
        add_request(CMD_COUNT, 8'h00, 1'b0, 1'b0);

        // Directed: fill the text to capacity and push a few appends past it.
        for (int i = 0; i < MAX_TEXT + 4; i++)
            add_request(CMD_APPEND, 8'(SYM_A + $urandom_range(0, 3)), 1'b0, 1'b0);
        add_request(CMD_COUNT, 8'h00, 1'b0, 1'b0);

        // Random: mostly text growth and well-formed queries over that text.
        while (pending_reqs.size() < N_ITEMS) begin
            if (pending_reqs.size() % 100 == 99) begin
                pending_reqs[pending_reqs.size() - 1].hold = 1'b1;
            end
            if (pending_reqs.size() == 500 || pending_reqs.size() == 950) begin
                add_request(CMD_CLEAR, $urandom, $urandom, $urandom, 1'b1);
                continue;
            end
            r = $urandom_range(0, 99);
            if (r < 38) begin
                sym = ($urandom_range(0, 9) == 0) ? 8'($urandom) : SYM_A + $urandom_range(0, 3);
                add_request(CMD_APPEND, sym, $urandom, $urandom);
            end else if (r < 78) begin
                add_query((r < 58) ? CMD_CONTAIN : CMD_LCS, $urandom_range(1, 8),
                          $urandom_range(0, 9) != 0);
            end else if (r < 88) begin
                add_request(CMD_COUNT, $urandom, $urandom, $urandom);
            end else if (r < 91) begin
                add_request($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI), $urandom,
                            $urandom, $urandom);
            end else begin
                add_request(($urandom_range(0, 1) != 0) ? CMD_CONTAIN : CMD_LCS,
                            $urandom, $urandom, $urandom);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d requests: %0d appends, %0d containment, %0d LCS steps,",
                 sent, cmd_seen[CMD_APPEND], cmd_seen[CMD_CONTAIN], cmd_seen[CMD_LCS]);
        $display("%0d counts, %0d clears, with idling on both sides and full-text drops.",
                 cmd_seen[CMD_COUNT], cmd_seen[CMD_CLEAR]);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
